FILE: rtl/mse_pkg.sv
// Shared types and constants of the MIPS subset execute unit.
package mse_pkg;

   localparam int unsigned REG_COUNT = 32;
   localparam int unsigned REG_AW    = 5;
   localparam int unsigned XLEN      = 32;
   localparam int unsigned IMM_W     = 16;
   localparam int unsigned FUNCT_W   = 11;
   localparam int unsigned IMM_SHIFT = 16;

   // Primary opcodes
   localparam logic [5:0] OP_RTYPE = 6'd0;
   localparam logic [5:0] OP_BEQ   = 6'd4;
   localparam logic [5:0] OP_BNE   = 6'd5;
   localparam logic [5:0] OP_ADDI  = 6'd8;
   localparam logic [5:0] OP_SLTI  = 6'd10;
   localparam logic [5:0] OP_ANDI  = 6'd12;
   localparam logic [5:0] OP_ORI   = 6'd13;
   localparam logic [5:0] OP_LUI   = 6'd15;
   localparam logic [5:0] OP_MUL   = 6'd28;

   // Low eleven bits of opcode-0 words (shamt and funct)
   localparam logic [FUNCT_W-1:0] FN_ADD     = 11'h020;
   localparam logic [FUNCT_W-1:0] FN_SUB     = 11'h022;
   localparam logic [FUNCT_W-1:0] FN_AND     = 11'h024;
   localparam logic [FUNCT_W-1:0] FN_OR      = 11'h025;
   localparam logic [FUNCT_W-1:0] FN_SLT     = 11'h02A;
   localparam logic [FUNCT_W-1:0] FN_SYSCALL = 11'h00C;

   // Syscall service codes in v0
   localparam logic [XLEN-1:0] SC_PRINT_INT  = 32'd1;
   localparam logic [XLEN-1:0] SC_EXIT       = 32'd10;
   localparam logic [XLEN-1:0] SC_PRINT_CHAR = 32'd11;

   // Fixed registers read by syscall
   localparam logic [REG_AW-1:0] REG_V0 = 5'd2;
   localparam logic [REG_AW-1:0] REG_A0 = 5'd4;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_PRINT_INT  = 3'd1,
      EV_PRINT_CHAR = 3'd2,
      EV_EXIT       = 3'd3,
      EV_UNKNOWN    = 3'd4
   } ev_kind_type;

   typedef enum logic [3:0] {
      K_ILLEGAL,
      K_ADD,
      K_SUB,
      K_AND,
      K_OR,
      K_SLT,
      K_MUL,
      K_BEQ,
      K_BNE,
      K_ADDI,
      K_SLTI,
      K_ANDI,
      K_ORI,
      K_LUI,
      K_SYSCALL
   } kind_type;

   // Classified instruction handed from front to back
   typedef struct packed {
      kind_type          kind;
      logic [REG_AW-1:0] ra_addr;
      logic [REG_AW-1:0] rb_addr;
      logic [REG_AW-1:0] wr_addr;   // zero when nothing is written
      logic [IMM_W-1:0]  imm;
   } dec_type;

   typedef struct packed {
      logic              illegal;
      logic              branch_taken;
      logic [IMM_W-1:0]  branch_offset;
      ev_kind_type       event_kind;
      logic [XLEN-1:0]   event_value;
   } result_type;

   // Front queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      dec_type dec;
   } head_type;

endpackage

FILE: rtl/mse_front.sv
// Front end: decodes instruction words and queues them for execution.
module mse_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [mse_pkg::XLEN-1:0]       req_instr_word,
   output mse_pkg::head_type              head,
   input  logic                           head_pop
);

   localparam int unsigned DEPTH = 2;

   mse_pkg::dec_type dec;
   mse_pkg::dec_type q_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   logic [5:0]                      op;
   logic [mse_pkg::REG_AW-1:0]      rs, rt, rd;
   logic [mse_pkg::FUNCT_W-1:0]     funct;

   assign op    = req_instr_word[31:26];
   assign rs    = req_instr_word[25:21];
   assign rt    = req_instr_word[20:16];
   assign rd    = req_instr_word[15:11];
   assign funct = req_instr_word[mse_pkg::FUNCT_W-1:0];

   always_comb begin
      dec.kind    = mse_pkg::K_ILLEGAL;
      dec.ra_addr = rs;
      dec.rb_addr = rt;
      dec.wr_addr = '0;
      dec.imm     = req_instr_word[mse_pkg::IMM_W-1:0];
      unique case (op)
         mse_pkg::OP_RTYPE: begin
            dec.wr_addr = rd;
            unique case (funct)
               mse_pkg::FN_ADD: dec.kind = mse_pkg::K_ADD;
               mse_pkg::FN_SUB: dec.kind = mse_pkg::K_SUB;
               mse_pkg::FN_AND: dec.kind = mse_pkg::K_AND;
               mse_pkg::FN_OR:  dec.kind = mse_pkg::K_OR;
               mse_pkg::FN_SLT: dec.kind = mse_pkg::K_SLT;
               mse_pkg::FN_SYSCALL: begin
                  dec.kind    = mse_pkg::K_SYSCALL;
                  dec.ra_addr = mse_pkg::REG_V0;
                  dec.rb_addr = mse_pkg::REG_A0;
                  dec.wr_addr = '0;
               end
               default: dec.wr_addr = '0;
            endcase
         end
         mse_pkg::OP_MUL: begin
            dec.kind    = mse_pkg::K_MUL;
            dec.wr_addr = rd;
         end
         mse_pkg::OP_BEQ:  dec.kind = mse_pkg::K_BEQ;
         mse_pkg::OP_BNE:  dec.kind = mse_pkg::K_BNE;
         mse_pkg::OP_ADDI: begin
            dec.kind    = mse_pkg::K_ADDI;
            dec.wr_addr = rt;
         end
         mse_pkg::OP_SLTI: begin
            dec.kind    = mse_pkg::K_SLTI;
            dec.wr_addr = rt;
         end
         mse_pkg::OP_ANDI: begin
            dec.kind    = mse_pkg::K_ANDI;
            dec.wr_addr = rt;
         end
         mse_pkg::OP_ORI: begin
            dec.kind    = mse_pkg::K_ORI;
            dec.wr_addr = rt;
         end
         mse_pkg::OP_LUI: begin
            dec.kind    = mse_pkg::K_LUI;
            dec.wr_addr = rt;
         end
         default: dec.kind = mse_pkg::K_ILLEGAL;
      endcase
   end

   assign full     = (cnt_ff == 2'(DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = head_pop && (cnt_ff != 2'd0);

   assign head.valid = (cnt_ff != 2'd0);
   assign head.dec   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

FILE: rtl/mse_back.sv
// Back end: register file, execute stage and result queue.
module mse_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mse_pkg::head_type                     head,
   output logic                                  head_pop,
   output logic                                  empty,
   input  logic                                  pop,
   output logic                                  rsp_illegal,
   output logic                                  rsp_branch_taken,
   output logic signed [mse_pkg::IMM_W-1:0]      rsp_branch_offset,
   output logic [2:0]                            rsp_event_kind,
   output logic signed [mse_pkg::XLEN-1:0]       rsp_event_value
);

   localparam int unsigned OUT_DEPTH = 2;

   // Register file: memory plus per-entry valid bits for the reset clear
   logic [mse_pkg::XLEN-1:0]      rf_mem [mse_pkg::REG_COUNT];
   logic [mse_pkg::REG_COUNT-1:0] rf_valid_ff;
   logic                          rf_we;
   logic [mse_pkg::REG_AW-1:0]    rf_waddr;
   logic [mse_pkg::XLEN-1:0]      rf_wdata;

   // Execute stage
   logic                     e_valid_ff, e_valid_in;
   mse_pkg::dec_type         e_ff;
   logic [mse_pkg::XLEN-1:0] rda_ff, rdb_ff, byp_ff;
   logic                     a_vld_ff, b_vld_ff, a_byp_ff, b_byp_ff;
   logic [mse_pkg::XLEN-1:0] opa, opb, simm, zimm, prod;
   logic                     e_load, e_fire;
   mse_pkg::result_type      res;
   logic [mse_pkg::XLEN-1:0] wdata;

   // Result queue
   mse_pkg::result_type out_ff [OUT_DEPTH];
   logic                out_wr_ff, out_wr_in, out_rd_ff, out_rd_in;
   logic [1:0]          out_cnt_ff, out_cnt_in;
   logic                out_full, out_pop;
   mse_pkg::result_type out_head;

   assign out_full = (out_cnt_ff == 2'(OUT_DEPTH));
   assign e_fire   = e_valid_ff && !out_full;
   assign e_load   = head.valid && (!e_valid_ff || e_fire);
   assign head_pop = e_load;

   always_comb begin
      e_valid_in = e_valid_ff;
      if (e_load) begin
         e_valid_in = 1'b1;
      end else if (e_fire) begin
         e_valid_in = 1'b0;
      end
   end

   // Read ports with write-through bypass for the result retiring this cycle
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_waddr] <= rf_wdata;
      end
      if (e_load) begin
         rda_ff   <= rf_mem[head.dec.ra_addr];
         rdb_ff   <= rf_mem[head.dec.rb_addr];
         a_vld_ff <= rf_valid_ff[head.dec.ra_addr];
         b_vld_ff <= rf_valid_ff[head.dec.rb_addr];
         a_byp_ff <= rf_we && (rf_waddr == head.dec.ra_addr);
         b_byp_ff <= rf_we && (rf_waddr == head.dec.rb_addr);
         byp_ff   <= rf_wdata;
         e_ff     <= head.dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
         e_valid_ff  <= 1'b0;
      end else begin
         e_valid_ff <= e_valid_in;
         if (rf_we) begin
            rf_valid_ff[rf_waddr] <= 1'b1;
         end
      end
   end

   assign opa  = a_byp_ff ? byp_ff : (a_vld_ff ? rda_ff : '0);
   assign opb  = b_byp_ff ? byp_ff : (b_vld_ff ? rdb_ff : '0);
   assign simm = {{(mse_pkg::XLEN-mse_pkg::IMM_W){e_ff.imm[mse_pkg::IMM_W-1]}}, e_ff.imm};
   assign zimm = {{(mse_pkg::XLEN-mse_pkg::IMM_W){1'b0}}, e_ff.imm};
   assign prod = opa * opb;

   always_comb begin
      res   = '0;
      wdata = '0;
      unique case (e_ff.kind)
         mse_pkg::K_ADD:  wdata = opa + opb;
         mse_pkg::K_SUB:  wdata = opa - opb;
         mse_pkg::K_AND:  wdata = opa & opb;
         mse_pkg::K_OR:   wdata = opa | opb;
         mse_pkg::K_SLT:  wdata = {31'd0, $signed(opa) < $signed(opb)};
         mse_pkg::K_MUL:  wdata = prod;
         mse_pkg::K_ADDI: wdata = opa + simm;
         mse_pkg::K_SLTI: wdata = {31'd0, $signed(opa) < $signed(simm)};
         mse_pkg::K_ANDI: wdata = opa & zimm;
         mse_pkg::K_ORI:  wdata = opa | zimm;
         mse_pkg::K_LUI:  wdata = {e_ff.imm, 16'd0};
         mse_pkg::K_BEQ: begin
            if (opa == opb) begin
               res.branch_taken  = 1'b1;
               res.branch_offset = e_ff.imm;
            end
         end
         mse_pkg::K_BNE: begin
            if (opa != opb) begin
               res.branch_taken  = 1'b1;
               res.branch_offset = e_ff.imm;
            end
         end
         mse_pkg::K_SYSCALL: begin
            // opa holds v0, opb holds a0
            if (opa == mse_pkg::SC_PRINT_INT) begin
               res.event_kind  = mse_pkg::EV_PRINT_INT;
               res.event_value = opb;
            end else if (opa == mse_pkg::SC_PRINT_CHAR) begin
               res.event_kind  = mse_pkg::EV_PRINT_CHAR;
               res.event_value = opb;
            end else if (opa == mse_pkg::SC_EXIT) begin
               res.event_kind  = mse_pkg::EV_EXIT;
            end else begin
               res.event_kind  = mse_pkg::EV_UNKNOWN;
               res.event_value = opa;
            end
         end
         default: res.illegal = 1'b1;
      endcase
   end

   // Retire: write back and push the result in the same cycle
   assign rf_we    = e_fire && (e_ff.wr_addr != '0);
   assign rf_waddr = e_ff.wr_addr;
   assign rf_wdata = wdata;

   assign out_pop  = pop && !empty;
   assign empty    = (out_cnt_ff == 2'd0);
   assign out_head = out_ff[out_rd_ff];

   always_comb begin
      out_wr_in  = e_fire  ? ~out_wr_ff : out_wr_ff;
      out_rd_in  = out_pop ? ~out_rd_ff : out_rd_ff;
      out_cnt_in = out_cnt_ff + 2'(e_fire) - 2'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (e_fire) begin
         out_ff[out_wr_ff] <= res;
      end
   end

   assign rsp_illegal       = out_head.illegal;
   assign rsp_branch_taken  = out_head.branch_taken;
   assign rsp_branch_offset = $signed(out_head.branch_offset);
   assign rsp_event_kind    = out_head.event_kind;
   assign rsp_event_value   = $signed(out_head.event_value);

`ifndef NO_ASSERTIONS
   a_out_cnt_range: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= 2'(OUT_DEPTH))
      else $error("result queue count out of range");

   a_no_write_on_illegal: assert property (@(posedge clock) disable iff (reset)
      (e_valid_ff && (e_ff.kind == mse_pkg::K_ILLEGAL)) |-> !rf_we)
      else $error("illegal instruction wrote the register file");

   a_reg0_never_valid: assert property (@(posedge clock) disable iff (reset)
      !rf_valid_ff[0])
      else $error("register zero was written");

   a_illegal_clean: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_illegal) |->
         (!rsp_branch_taken && (rsp_event_kind == mse_pkg::EV_NONE)))
      else $error("illegal result carries other fields");

   a_fire_pushes: assert property (@(posedge clock) disable iff (reset)
      (e_fire && !out_pop) |=> (out_cnt_ff == $past(out_cnt_ff) + 2'd1))
      else $error("retired instruction did not enter the result queue");
`endif

endmodule

FILE: rtl/mips_subset_execute_unit.sv
// Top level of the MIPS subset execute unit: front end, back end and their link.
//
// Requests are 32-bit MIPS instruction words on req_instr_word, taken at a
// rising edge where push is high and full is low. Each request yields one
// result: illegal, branch_taken, branch_offset, event_kind, event_value.
// A result is on the rsp_ ports while empty is low and leaves at an edge
// where pop is also high. Results come out in request order.
// A request taken at an edge is decoded into the front queue, loaded into the
// execute stage with its operands, then executed and pushed into the result
// queue. Throughput is one request per cycle while the receiver keeps popping:
// the front end decodes into a two-entry queue, the back end reads both operands
// from the register file into the execute stage and then executes, writes back
// and queues the result, with a bypass for a result retiring in the same cycle.
// Reset clears the queues and marks every register as zero; no clearing
// pass is needed, so requests are taken as soon as reset is released.
// When the receiver stops popping, the two-entry result queue fills, the
// execute stage holds, the front queue fills and full rises.
module mips_subset_execute_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic [mse_pkg::XLEN-1:0]              req_instr_word,
   output logic                                  empty,
   input  logic                                  pop,
   output logic                                  rsp_illegal,
   output logic                                  rsp_branch_taken,
   output logic signed [mse_pkg::IMM_W-1:0]      rsp_branch_offset,
   output logic [2:0]                            rsp_event_kind,
   output logic signed [mse_pkg::XLEN-1:0]       rsp_event_value
);

   mse_pkg::head_type head;
   logic              head_pop;

   mse_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_instr_word (req_instr_word),
      .head           (head),
      .head_pop       (head_pop)
   );

   mse_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .head_pop          (head_pop),
      .empty             (empty),
      .pop               (pop),
      .rsp_illegal       (rsp_illegal),
      .rsp_branch_taken  (rsp_branch_taken),
      .rsp_branch_offset (rsp_branch_offset),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_event_value   (rsp_event_value)
   );

endmodule
